>>> sv/nccs_pkg.sv
// Package for the normalized cross-correlation score unit.
// Widths, sequencer step codes and the grey conversion; no dependencies.
package nccs_pkg;

    localparam longint MAX_WINDOW_PIXELS = 65536;

    localparam int CNT_W = $clog2(MAX_WINDOW_PIXELS + 1);
    localparam int SUM_W = $clog2(MAX_WINDOW_PIXELS * 255 + 1);
    localparam int SQ_W  = $clog2(MAX_WINDOW_PIXELS * 65025 + 1);
    // n*Sxx - Sx^2 and friends
    localparam int AW    = CNT_W + SQ_W;
    // widest product: C^2 * 2^30, and A*B*mid^2
    localparam int P_W   = 2 * AW + 30;
    localparam int MA_W  = 2 * AW;
    localparam int MB_W  = AW;

    localparam int HALF  = 32768;
    localparam int HW    = 16;
    localparam int M2_W  = 31;
    localparam int SCORE_W = 17;

    localparam logic [3:0] STP_NSXX = 4'd0;
    localparam logic [3:0] STP_SXSX = 4'd1;
    localparam logic [3:0] STP_NSYY = 4'd2;
    localparam logic [3:0] STP_SYSY = 4'd3;
    localparam logic [3:0] STP_NSXY = 4'd4;
    localparam logic [3:0] STP_SXSY = 4'd5;
    localparam logic [3:0] STP_AB   = 4'd6;
    localparam logic [3:0] STP_CC   = 4'd7;
    localparam logic [3:0] STP_SQ   = 4'd8;
    localparam logic [3:0] STP_PM   = 4'd9;

    // floor((b+g+r)/3) via reciprocal 683/2048, exact for sums up to 765
    function automatic logic [7:0] grey(input logic [7:0] b, input logic [7:0] g,
                                        input logic [7:0] r);
        logic [9:0]  s;
        logic [18:0] p;
        s = {2'b00, b} + {2'b00, g} + {2'b00, r};
        p = 19'(s) * 19'd683;
        return p[18:11];
    endfunction

endpackage

>>> sv/normalized_cross_correlation_score_unit.sv
// Top level of the normalized cross-correlation score unit.
// Depends on nccs_pkg and nccs_mul.
//
// Each accepted pixel pair is transferred in ST_IDLE, then accumulated in ST_ACC.
// The pair marked last then starts the score: a single shift-add multiplier
// retires one multiplier bit per cycle and runs eight products to form the
// variances, covariance, A*B and C^2, then fifteen or sixteen binary-search
// steps that each square the candidate and multiply it into A*B. The run
// time is set by operand magnitudes; an empty or flat window stops after
// the first four products. The input is not ready meanwhile. The score is
// held in an output register until taken.
module normalized_cross_correlation_score_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [7:0]                     s_tmpl_blue,
    input  logic [7:0]                     s_tmpl_green,
    input  logic [7:0]                     s_tmpl_red,
    input  logic [7:0]                     s_srch_blue,
    input  logic [7:0]                     s_srch_green,
    input  logic [7:0]                     s_srch_red,
    input  logic                           s_in_bounds,
    input  logic                           s_last_pixel,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [nccs_pkg::SCORE_W-1:0]   m_score,
    output logic                           m_degenerate
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_ACC  = 3'd1;
    localparam logic [2:0] ST_LOAD = 3'd2;
    localparam logic [2:0] ST_WAIT = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    localparam int AW = nccs_pkg::AW;
    localparam int HW = nccs_pkg::HW;

    logic [2:0] state_reg;
    logic [3:0] step_reg;

    logic [nccs_pkg::CNT_W-1:0] n_reg;
    logic [nccs_pkg::SUM_W-1:0] sx_reg, sy_reg;
    logic [nccs_pkg::SQ_W-1:0]  sxx_reg, syy_reg, sxy_reg;

    logic [7:0] tg_reg, sg_reg;
    logic       inb_reg, last_reg;

    logic [AW-1:0]              t1_reg, a_reg, b_reg, c_reg;
    logic                       cneg_reg, deg_reg;
    logic [nccs_pkg::MA_W-1:0]  prod_reg;
    logic [nccs_pkg::P_W-1:0]   rhs_reg;
    logic [HW-1:0]              lo_reg, hi_reg;
    logic [nccs_pkg::M2_W-1:0]  m2_reg;

    logic                       mv_reg;
    logic [nccs_pkg::SCORE_W-1:0] score_reg;
    logic                       mdeg_reg;

    logic                       mul_start, mul_done;
    logic [nccs_pkg::MA_W-1:0]  mul_a;
    logic [nccs_pkg::MB_W-1:0]  mul_b;
    logic [nccs_pkg::P_W-1:0]   mul_p;
    logic [AW-1:0]              p_lo;
    logic [HW:0]                mid_sum;
    logic [HW-1:0]              mid;
    logic                       clear_acc;

    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = mv_reg;
    assign m_score      = score_reg;
    assign m_degenerate = mdeg_reg;
    assign mul_start    = (state_reg == ST_LOAD);
    assign p_lo         = mul_p[AW-1:0];
    assign mid_sum      = {1'b0, lo_reg} + {1'b0, hi_reg} + {{HW{1'b0}}, !cneg_reg};
    assign mid          = mid_sum[HW:1];
    assign clear_acc    = (state_reg == ST_DONE) && (!mv_reg || m_ready);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (step_reg)
            nccs_pkg::STP_NSXX: begin
                mul_a = nccs_pkg::MA_W'(sxx_reg); mul_b = nccs_pkg::MB_W'(n_reg);
            end
            nccs_pkg::STP_SXSX: begin
                mul_a = nccs_pkg::MA_W'(sx_reg); mul_b = nccs_pkg::MB_W'(sx_reg);
            end
            nccs_pkg::STP_NSYY: begin
                mul_a = nccs_pkg::MA_W'(syy_reg); mul_b = nccs_pkg::MB_W'(n_reg);
            end
            nccs_pkg::STP_SYSY: begin
                mul_a = nccs_pkg::MA_W'(sy_reg); mul_b = nccs_pkg::MB_W'(sy_reg);
            end
            nccs_pkg::STP_NSXY: begin
                mul_a = nccs_pkg::MA_W'(sxy_reg); mul_b = nccs_pkg::MB_W'(n_reg);
            end
            nccs_pkg::STP_SXSY: begin
                mul_a = nccs_pkg::MA_W'(sx_reg); mul_b = nccs_pkg::MB_W'(sy_reg);
            end
            nccs_pkg::STP_AB: begin
                mul_a = nccs_pkg::MA_W'(a_reg); mul_b = b_reg;
            end
            nccs_pkg::STP_CC: begin
                mul_a = nccs_pkg::MA_W'(c_reg); mul_b = c_reg;
            end
            nccs_pkg::STP_SQ: begin
                mul_a = nccs_pkg::MA_W'(mid); mul_b = nccs_pkg::MB_W'(mid);
            end
            nccs_pkg::STP_PM: begin
                mul_a = prod_reg; mul_b = nccs_pkg::MB_W'(m2_reg);
            end
            default: begin
                mul_a = '0; mul_b = '0;
            end
        endcase
    end

    nccs_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .done    (mul_done),
        .product (mul_p)
    );

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= nccs_pkg::STP_NSXX;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        state_reg <= ST_ACC;
                    end
                end
                ST_ACC: begin
                    step_reg  <= nccs_pkg::STP_NSXX;
                    state_reg <= last_reg ? ST_LOAD : ST_IDLE;
                end
                ST_LOAD: begin
                    state_reg <= ST_WAIT;
                end
                ST_WAIT: begin
                    if (mul_done) begin
                        state_reg <= ST_LOAD;
                        case (step_reg)
                            nccs_pkg::STP_SYSY: begin
                                if (a_reg == '0 || (t1_reg - p_lo) == '0) begin
                                    state_reg <= ST_DONE;
                                end else begin
                                    step_reg <= nccs_pkg::STP_NSXY;
                                end
                            end
                            nccs_pkg::STP_CC: begin
                                step_reg <= nccs_pkg::STP_SQ;
                                if (lo_reg == hi_reg) begin
                                    state_reg <= ST_DONE;
                                end
                            end
                            nccs_pkg::STP_SQ: step_reg <= nccs_pkg::STP_PM;
                            nccs_pkg::STP_PM: begin
                                step_reg <= nccs_pkg::STP_SQ;
                                // loop ends once the interval has closed
                                if (!cneg_reg) begin
                                    if (mul_p <= rhs_reg) begin
                                        if (mid == hi_reg) state_reg <= ST_DONE;
                                    end else if (lo_reg == mid - 1'b1) begin
                                        state_reg <= ST_DONE;
                                    end
                                end else begin
                                    if (mul_p >= rhs_reg) begin
                                        if (mid == lo_reg) state_reg <= ST_DONE;
                                    end else if (hi_reg == mid + 1'b1) begin
                                        state_reg <= ST_DONE;
                                    end
                                end
                            end
                            default: step_reg <= step_reg + 4'd1;
                        endcase
                    end
                end
                ST_DONE: begin
                    if (!mv_reg || m_ready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_valid) begin
            tg_reg   <= nccs_pkg::grey(s_tmpl_blue, s_tmpl_green, s_tmpl_red);
            sg_reg   <= nccs_pkg::grey(s_srch_blue, s_srch_green, s_srch_red);
            inb_reg  <= s_in_bounds;
            last_reg <= s_last_pixel;
        end
        if (state_reg == ST_ACC) begin
            lo_reg  <= '0;
            hi_reg  <= HW'(nccs_pkg::HALF);
            deg_reg <= 1'b1;
        end
        if (state_reg == ST_WAIT && mul_done) begin
            case (step_reg)
                nccs_pkg::STP_NSXX, nccs_pkg::STP_NSYY, nccs_pkg::STP_NSXY: t1_reg <= p_lo;
                nccs_pkg::STP_SXSX: a_reg <= t1_reg - p_lo;
                nccs_pkg::STP_SYSY: begin
                    b_reg   <= t1_reg - p_lo;
                    deg_reg <= (a_reg == '0 || (t1_reg - p_lo) == '0);
                end
                nccs_pkg::STP_SXSY: begin
                    cneg_reg <= t1_reg < p_lo;
                    c_reg    <= (t1_reg < p_lo) ? p_lo - t1_reg : t1_reg - p_lo;
                end
                nccs_pkg::STP_AB: prod_reg <= mul_p[nccs_pkg::MA_W-1:0];
                nccs_pkg::STP_CC: rhs_reg <= {mul_p[nccs_pkg::P_W-31:0], 30'd0};
                nccs_pkg::STP_SQ: m2_reg <= mul_p[nccs_pkg::M2_W-1:0];
                nccs_pkg::STP_PM: begin
                    if (!cneg_reg) begin
                        if (mul_p <= rhs_reg) lo_reg <= mid;
                        else                  hi_reg <= mid - 1'b1;
                    end else begin
                        if (mul_p >= rhs_reg) hi_reg <= mid;
                        else                  lo_reg <= mid + 1'b1;
                    end
                end
                default: t1_reg <= t1_reg;
            endcase
        end
    end

    // window accumulators
    always_ff @(posedge aclk) begin
        if (!aresetn || clear_acc) begin
            n_reg   <= '0;
            sx_reg  <= '0;
            sy_reg  <= '0;
            sxx_reg <= '0;
            syy_reg <= '0;
            sxy_reg <= '0;
        end else if (state_reg == ST_ACC && inb_reg
                     && n_reg < nccs_pkg::CNT_W'(nccs_pkg::MAX_WINDOW_PIXELS)) begin
            n_reg   <= n_reg + 1'b1;
            sx_reg  <= sx_reg + nccs_pkg::SUM_W'(tg_reg);
            sy_reg  <= sy_reg + nccs_pkg::SUM_W'(sg_reg);
            sxx_reg <= sxx_reg + nccs_pkg::SQ_W'(16'(tg_reg) * 16'(tg_reg));
            syy_reg <= syy_reg + nccs_pkg::SQ_W'(16'(sg_reg) * 16'(sg_reg));
            sxy_reg <= sxy_reg + nccs_pkg::SQ_W'(16'(tg_reg) * 16'(sg_reg));
        end
    end

    // result register; lo never exceeds HALF so the score stays in 0..65536
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mv_reg <= 1'b0;
        end else if (clear_acc) begin
            mv_reg <= 1'b1;
        end else if (m_ready) begin
            mv_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (clear_acc) begin
            mdeg_reg <= deg_reg;
            if (deg_reg) begin
                score_reg <= '0;
            end else if (cneg_reg) begin
                score_reg <= nccs_pkg::SCORE_W'(nccs_pkg::HALF) - nccs_pkg::SCORE_W'(lo_reg);
            end else begin
                score_reg <= nccs_pkg::SCORE_W'(nccs_pkg::HALF) + nccs_pkg::SCORE_W'(lo_reg);
            end
        end
    end

endmodule

>>> sv/nccs_mul.sv
// Shift-add multiplier, one multiplier bit per cycle, stops when the rest is zero.
// Depends on nccs_pkg for operand and product widths.
module nccs_mul (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [nccs_pkg::MA_W-1:0] op_a,
    input  logic [nccs_pkg::MB_W-1:0] op_b,
    output logic                      done,
    output logic [nccs_pkg::P_W-1:0]  product
);

    logic                      run_reg;
    logic [nccs_pkg::P_W-1:0]  acc_reg;
    logic [nccs_pkg::P_W-1:0]  a_reg;
    logic [nccs_pkg::MB_W-1:0] b_reg;

    assign done    = run_reg && (b_reg == '0);
    assign product = acc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg <= 1'b0;
        end else if (start) begin
            run_reg <= 1'b1;
        end else if (done) begin
            run_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            acc_reg <= '0;
            a_reg   <= nccs_pkg::P_W'(op_a);
            b_reg   <= op_b;
        end else if (run_reg && b_reg != '0) begin
            if (b_reg[0]) begin
                acc_reg <= acc_reg + a_reg;
            end
            a_reg <= {a_reg[nccs_pkg::P_W-2:0], 1'b0};
            b_reg <= b_reg >> 1;
        end
    end

endmodule

>>> sv/nccs_checker.sv
// Port-level checks for the normalized cross-correlation score unit.
// Depends on nccs_pkg; bound to the top level below.
module nccs_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_valid,
    input logic                         s_ready,
    input logic                         s_last_pixel,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic [nccs_pkg::SCORE_W-1:0] m_score,
    input logic                         m_degenerate
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_score) && $stable(m_degenerate))
        else $error("result changed while stalled");

    a_deg_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_degenerate |-> m_score == '0)
        else $error("degenerate result with nonzero score");

    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_score <= nccs_pkg::SCORE_W'(2 * nccs_pkg::HALF))
        else $error("score out of range");

    a_no_spurious: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !s_last_pixel && !m_valid |=> !m_valid)
        else $error("result without a last pair");

    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input ready during accumulate");

endmodule

bind normalized_cross_correlation_score_unit nccs_checker u_nccs_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .s_last_pixel (s_last_pixel),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_score      (m_score),
    .m_degenerate (m_degenerate)
);

>>> sim/tb.sv
// Testbench for normalized_cross_correlation_score_unit.
// Depends on nccs_pkg and the unit's RTL. A directed table and random windows
// in sender-idle and receiver-stall phases are checked by an in-bench model.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint WIN_MAX = nccs_pkg::MAX_WINDOW_PIXELS;
    localparam int     LIMIT   = 4000000;
    localparam int     DRAIN   = 3000;

    typedef struct {
        logic [7:0] tb_, tg_, tr_, sb_, sg_, sr_;
        logic       ib, lp;
        bit         typed;
        logic [16:0] score;
        logic       degen;
    } pair_row_t;

    typedef struct {
        logic [16:0] score;
        logic        degen;
    } score_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_tmpl_blue = '0, s_tmpl_green = '0, s_tmpl_red = '0;
    logic [7:0]  s_srch_blue = '0, s_srch_green = '0, s_srch_red = '0;
    logic        s_in_bounds = 1'b0, s_last_pixel = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [nccs_pkg::SCORE_W-1:0] m_score;
    logic        m_degenerate;

    normalized_cross_correlation_score_unit dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    score_t  score_q[$];
    int      errors = 0;
    int      cycles = 0;
    int      send_idle_pct = 0;
    int      recv_stall_pct = 0;

    // window accumulators
    longint unsigned win_n, win_sx, win_sy, win_sxx, win_syy, win_sxy;

    task automatic clear_window();
        win_n = 0; win_sx = 0; win_sy = 0;
        win_sxx = 0; win_syy = 0; win_sxy = 0;
    endtask

    task automatic score_pair(input pair_row_t p, output bit got, output score_t r);
        longint unsigned gt, gs, a, b, pxy, pxs, cmag;
        logic [191:0] prod, rhs, lhs;
        int unsigned lo, hi, mid;
        bit cneg;
        gt = (longint'(p.tb_) + p.tg_ + p.tr_) / 3;
        gs = (longint'(p.sb_) + p.sg_ + p.sr_) / 3;
        got = 0;
        r.score = '0;
        r.degen = 1'b0;
        if (p.ib && win_n < WIN_MAX) begin
            win_n++;
            win_sx += gt; win_sy += gs;
            win_sxx += gt * gt; win_syy += gs * gs; win_sxy += gt * gs;
        end
        if (!p.lp) return;
        got = 1;
        a = win_n * win_sxx - win_sx * win_sx;
        b = win_n * win_syy - win_sy * win_sy;
        if (win_n == 0 || a == 0 || b == 0) begin
            r.degen = 1'b1;
            clear_window();
            return;
        end
        pxy = win_n * win_sxy;
        pxs = win_sx * win_sy;
        cneg = pxy < pxs;
        cmag = cneg ? pxs - pxy : pxy - pxs;
        prod = 192'(a) * 192'(b);
        rhs = (192'(cmag) * 192'(cmag)) << 30;
        lo = 0;
        hi = 32768;
        if (!cneg) begin
            while (lo < hi) begin
                mid = (lo + hi + 1) / 2;
                lhs = prod * 192'(mid * mid);
                if (lhs <= rhs) lo = mid;
                else hi = mid - 1;
            end
            r.score = 17'(32768 + lo);
        end else begin
            while (lo < hi) begin
                mid = (lo + hi) / 2;
                lhs = prod * 192'(mid * mid);
                if (lhs >= rhs) hi = mid;
                else lo = mid + 1;
            end
            r.score = 17'(32768 - lo);
        end
        clear_window();
    endtask

    // one pixel-pair transfer, with random idle cycles ahead of it
    task automatic send_pair(input pair_row_t p);
        bit got;
        score_t r;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_tmpl_blue <= p.tb_; s_tmpl_green <= p.tg_; s_tmpl_red <= p.tr_;
        s_srch_blue <= p.sb_; s_srch_green <= p.sg_; s_srch_red <= p.sr_;
        s_in_bounds <= p.ib; s_last_pixel <= p.lp;
        do @(posedge aclk); while (!s_ready);
        score_pair(p, got, r);
        if (got) begin
            if (p.typed) begin
                r.score = p.score;
                r.degen = p.degen;
            end
            score_q.push_back(r);
        end
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (score_q.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [7:0] near(input logic [7:0] v, input int spread);
        int x;
        x = int'(v) + $urandom_range(2 * spread) - spread;
        if (x < 0) x = 0;
        if (x > 255) x = 255;
        return 8'(x);
    endfunction

    // one random window; returns number of pairs sent
    task automatic send_window(output int sent);
        int len, mode;
        pair_row_t p;
        logic [7:0] flat;
        len = ($urandom_range(19) == 0) ? $urandom_range(400, 1) : $urandom_range(12, 1);
        mode = $urandom_range(5);
        flat = 8'($urandom);
        for (int i = 0; i < len; i++) begin
            p.tb_ = 8'($urandom); p.tg_ = 8'($urandom); p.tr_ = 8'($urandom);
            case (mode)
                1: begin
                    p.sb_ = near(p.tb_, 8); p.sg_ = near(p.tg_, 8); p.sr_ = near(p.tr_, 8);
                end
                2: begin
                    p.sb_ = ~p.tb_; p.sg_ = ~p.tg_; p.sr_ = near(~p.tr_, 4);
                end
                3: begin
                    p.sb_ = flat; p.sg_ = flat; p.sr_ = flat;
                end
                default: begin
                    p.sb_ = 8'($urandom); p.sg_ = 8'($urandom); p.sr_ = 8'($urandom);
                end
            endcase
            p.ib = ($urandom_range(9) != 0);
            // noise: stray last flags inside a window
            p.lp = (i == len - 1) || ($urandom_range(39) == 0);
            p.typed = 0;
            p.score = '0;
            p.degen = 1'b0;
            send_pair(p);
        end
        sent = len;
    endtask

    pair_row_t pair_table[15] = '{
        '{8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   1'b0, 1'b1, 1, 17'd0,     1'b1},
        '{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 1'b1, 1, 17'd0,     1'b1},
        '{8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   1'b1, 1'b0, 0, 17'd0,     1'b0},
        '{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 1'b1, 1, 17'd65536, 1'b0},
        '{8'd0,   8'd0,   8'd0,   8'd255, 8'd255, 8'd255, 1'b1, 1'b0, 0, 17'd0,     1'b0},
        '{8'd255, 8'd255, 8'd255, 8'd0,   8'd0,   8'd0,   1'b1, 1'b1, 1, 17'd0,     1'b0},
        '{8'd10,  8'd20,  8'd30,  8'd7,   8'd7,   8'd7,   1'b1, 1'b0, 0, 17'd0,     1'b0},
        '{8'd200, 8'd201, 8'd202, 8'd7,   8'd7,   8'd7,   1'b1, 1'b1, 1, 17'd0,     1'b1},
        '{8'd255, 8'd0,   8'd255, 8'd1,   8'd2,   8'd3,   1'b1, 1'b0, 0, 17'd0,     1'b0},
        '{8'd0,   8'd255, 8'd0,   8'd99,  8'd17,  8'd250, 1'b0, 1'b0, 0, 17'd0,     1'b0},
        '{8'd1,   8'd2,   8'd3,   8'd200, 8'd100, 8'd50,  1'b1, 1'b0, 0, 17'd0,     1'b0},
        '{8'd128, 8'd64,  8'd32,  8'd16,  8'd8,   8'd4,   1'b1, 1'b0, 0, 17'd0,     1'b0},
        '{8'd90,  8'd90,  8'd91,  8'd255, 8'd0,   8'd0,   1'b0, 1'b1, 0, 17'd0,     1'b0},
        '{8'd5,   8'd250, 8'd128, 8'd77,  8'd177, 8'd33,  1'b1, 1'b0, 0, 17'd0,     1'b0},
        '{8'd250, 8'd5,   8'd127, 8'd170, 8'd70,  8'd222, 1'b1, 1'b1, 0, 17'd0,     1'b0}
    };

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        score_t want;
        if (aresetn && m_valid && m_ready) begin
            if (score_q.size() == 0) begin
                $error("unexpected result score=%0d degenerate=%0b", m_score, m_degenerate);
                errors++;
            end else begin
                want = score_q.pop_front();
                if (m_score !== want.score) begin
                    $error("score: expected %0d, got %0d", want.score, m_score);
                    errors++;
                end
                if (m_degenerate !== want.degen) begin
                    $error("degenerate: expected %0b, got %0b", want.degen, m_degenerate);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    initial begin
        int sent, total;
        int idle_set[4] = '{0, 54, 0, 31};
        int stall_set[4] = '{0, 0, 54, 31};
        clear_window();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (pair_table[i]) send_pair(pair_table[i]);
        wait_drained();

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = idle_set[ph];
            recv_stall_pct = stall_set[ph];
            total = 0;
            while (total < 200) begin
                send_window(sent);
                total += sent;
            end
            // sender holds off until the unit has drained
            wait_drained();
        end

        s_valid <= 1'b0;
        while (score_q.size() != 0) @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);
        if (errors == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end
endmodule
